[hdl/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on aclk outside reset
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked on aclk outside reset
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/rrsd_pkg.sv]
// types and constants of the ratio rise spillover detector
`timescale 1ns / 1ps
package rrsd_pkg;

    localparam int RATIO_W   = 32;
    localparam int LIMIT_W   = 40;
    localparam int MULT_W    = 8;
    localparam int HIT_W     = 8;
    localparam int PCT_W     = 7;
    localparam int FRAC_W    = 16;
    localparam int LEVEL_W   = 16;
    localparam int IN_DATA_W = 32;
    localparam int IN_USER_W = 3;
    localparam int OUT_W     = 80;
    localparam int CFG_W     = 8;
    localparam int CFG_A_W   = 2;

    localparam logic [RATIO_W-1:0] ONE_Q16   = 32'h0001_0000;
    localparam logic [RATIO_W-1:0] RATIO_MAX = 32'hFFFF_FFFF;
    localparam logic [PCT_W-1:0]   PCT_SCALE = 7'd100;
    localparam logic [HIT_W-1:0]   HIT_MAX   = 8'hFF;

    localparam logic [1:0] ACT_BASELINE = 2'd1;
    localparam logic [1:0] ACT_CHECK    = 2'd2;

    localparam logic [CFG_A_W-1:0] CFG_MONITOR = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_RISE    = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_THRESH  = 2'd2;

    localparam logic             MONITOR_RST = 1'b1;
    localparam logic [PCT_W-1:0] RISE_RST    = 7'd10;
    localparam logic [HIT_W-1:0] THRESH_RST  = 8'd3;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

[hdl/rrsd_serial_div.sv]
// restoring divider, one quotient bit per cycle, dividend left aligned
`timescale 1ns / 1ps
module rrsd_serial_div
    import rrsd_pkg::*;
#(
    parameter int N_W   = 48,
    parameter int D_W   = 16,
    parameter int CNT_W = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [N_W-1:0]   dividend,
    input  logic [D_W-1:0]   divisor,
    input  logic [CNT_W-1:0] steps,
    output logic [N_W-1:0]   quotient,
    output unit_status_t     status
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [N_W-1:0]   num_reg;
    logic [D_W-1:0]   den_reg;
    logic [D_W-1:0]   rem_reg;
    logic [N_W-1:0]   quot_reg;
    logic [D_W:0]     trial;
    logic [D_W:0]     diff;
    logic             fits;
    logic [D_W-1:0]   rem_next;

    always_comb begin
        trial    = {rem_reg, num_reg[N_W-1]};
        fits     = (trial >= {1'b0, den_reg});
        diff     = trial - {1'b0, den_reg};
        rem_next = fits ? diff[D_W-1:0] : trial[D_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg  <= dividend;
            den_reg  <= divisor;
            rem_reg  <= '0;
            quot_reg <= '0;
        end else if (busy_reg) begin
            num_reg  <= {num_reg[N_W-2:0], 1'b0};
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[N_W-2:0], fits};
        end
    end

    assign quotient    = quot_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

[hdl/rrsd_serial_mul.sv]
// shift-add multiplier, one multiplicand bit per cycle, lsb first
`timescale 1ns / 1ps
module rrsd_serial_mul
    import rrsd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [RATIO_W-1:0] multiplicand,
    input  logic [MULT_W-1:0]  multiplier,
    output logic [LIMIT_W-1:0] product,
    output unit_status_t       status
);

    localparam int STEPS = RATIO_W;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [MULT_W-1:0]  mul_reg;
    logic [MULT_W-1:0]  hi_reg;
    logic [RATIO_W-1:0] lo_reg;
    logic [MULT_W:0]    part_sum;

    // add the multiplier under the next low bit, then shift one place right
    assign part_sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mul_reg} : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mul_reg <= multiplier;
            hi_reg  <= '0;
            lo_reg  <= multiplicand;
        end else if (busy_reg) begin
            hi_reg <= part_sum[MULT_W:1];
            lo_reg <= {part_sum[0], lo_reg[RATIO_W-1:1]};
        end
    end

    assign product     = {hi_reg, lo_reg};
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

[hdl/ratio_rise_spillover_detector.sv]
// top level of the ratio rise spillover detector
`timescale 1ns / 1ps
`include "assert_macros.svh"
// One word in, one word out. After a word is accepted, the red/green quotient
// comes out of the serial divider one bit per cycle; m_tvalid rises when that
// and any latch below are done and the output register is free, and s_tready
// returns at the same edge, so a new word is not taken before the last one has
// left the core. The first check-phase word while monitoring is on (once after
// reset) also latches the average and rise limit: the divider forms the average
// of the baseline ratios, the multiplier scales it by 100 plus the rise percent,
// and the divider then divides the product by 100. A new word is taken whenever
// the core is idle, even while the last result still waits on m_tready; that
// word then holds in the core until the output register frees. Configuration
// writes take effect at once.
module ratio_rise_spillover_detector
    import rrsd_pkg::*;
#(
    parameter int SENSOR_BITS = 16,
    parameter int COUNT_BITS  = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_A_W-1:0]   cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // red_level[15:0], green_level[31:16]
    input  logic [IN_DATA_W-1:0] s_tdata,
    // action[1:0], detector_calibrated[2]
    input  logic [IN_USER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // ratio_value[31:0], baseline_average[63:32], hit_count[71:64],
    // spill_detected[72], alarm_pulse[73], zero fill above
    output logic [OUT_W-1:0]     m_tdata
);

    localparam int SENS_W = (SENSOR_BITS < LEVEL_W) ? SENSOR_BITS : LEVEL_W;
    localparam int RAT_W  = SENS_W + FRAC_W;
    localparam int SUM_W  = RATIO_W + COUNT_BITS;
    localparam int NUM_W  = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;
    localparam int DEN_A  = (COUNT_BITS > SENS_W) ? COUNT_BITS : SENS_W;
    localparam int DEN_W  = (DEN_A > PCT_W) ? DEN_A : PCT_W;
    localparam int STEP_W = $clog2(NUM_W + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RATIO = 3'd1;
    localparam logic [2:0] ST_AVG   = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_SCALE = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic                  monitor_reg;
    logic [PCT_W-1:0]      rise_pct_reg;
    logic [HIT_W-1:0]      thresh_reg;
    logic [1:0]            act_reg;
    logic                  cal_reg;
    logic [SENS_W-1:0]     red_reg;
    logic [SENS_W-1:0]     green_reg;
    logic [RATIO_W-1:0]    ratio_reg, ratio_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  latched_reg, latched_next;
    logic [RATIO_W-1:0]    average_reg, average_next;
    logic [LIMIT_W-1:0]    limit_reg, limit_next;
    logic [HIT_W-1:0]      hits_reg, hits_next;
    logic                  detected_reg, detected_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]      m_tdata_reg, m_tdata_next;
    logic                  pulse;
    logic                  accept;
    logic                  out_free;
    logic                  need_latch;

    logic                  div_start;
    logic [NUM_W-1:0]      div_dividend;
    logic [DEN_W-1:0]      div_divisor;
    logic [STEP_W-1:0]     div_steps;
    logic [NUM_W-1:0]      div_quot;
    unit_status_t          div_stat;
    logic                  mul_start;
    logic [LIMIT_W-1:0]    mul_product;
    unit_status_t          mul_stat;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign need_latch = monitor_reg && (act_reg == ACT_CHECK) && !latched_reg;

    rrsd_serial_div #(
        .N_W   (NUM_W),
        .D_W   (DEN_W),
        .CNT_W (STEP_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .quotient (div_quot),
        .status   (div_stat)
    );

    rrsd_serial_mul u_mul (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (mul_start),
        .multiplicand (average_reg),
        .multiplier   (MULT_W'(PCT_SCALE) + MULT_W'(rise_pct_reg)),
        .product      (mul_product),
        .status       (mul_stat)
    );

    always_comb begin
        state_next    = state_reg;
        ratio_next    = ratio_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        latched_next  = latched_reg;
        average_next  = average_reg;
        limit_next    = limit_reg;
        hits_next     = hits_reg;
        detected_next = detected_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        pulse         = 1'b0;
        div_start     = 1'b0;
        div_dividend  = NUM_W'({s_tdata[SENS_W-1:0], {FRAC_W{1'b0}}}) << (NUM_W - RAT_W);
        div_divisor   = DEN_W'(s_tdata[LEVEL_W +: SENS_W]);
        div_steps     = STEP_W'(RAT_W);
        mul_start     = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    div_start  = 1'b1;
                    state_next = ST_RATIO;
                end
            end
            ST_RATIO: begin
                div_dividend = NUM_W'(sum_reg) << (NUM_W - SUM_W);
                div_divisor  = DEN_W'(count_reg);
                div_steps    = STEP_W'(SUM_W);
                if (div_stat.done) begin
                    if (green_reg == '0) begin
                        ratio_next = (red_reg == '0) ? ONE_Q16 : RATIO_MAX;
                    end else begin
                        ratio_next = div_quot[RATIO_W-1:0];
                    end
                    if (need_latch && (count_reg != '0)) begin
                        div_start  = 1'b1;
                        state_next = ST_AVG;
                    end else if (need_latch) begin
                        // no baseline samples: average and limit stay zero
                        average_next = '0;
                        limit_next   = '0;
                        latched_next = 1'b1;
                        state_next   = ST_DONE;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_AVG: begin
                if (div_stat.done) begin
                    average_next = div_quot[RATIO_W-1:0];
                    state_next   = ST_MUL;
                end
            end
            ST_MUL: begin
                div_dividend = NUM_W'(mul_product) << (NUM_W - LIMIT_W);
                div_divisor  = DEN_W'(PCT_SCALE);
                div_steps    = STEP_W'(LIMIT_W);
                if (!mul_stat.busy && !mul_stat.done) begin
                    mul_start = 1'b1;
                end else if (mul_stat.done) begin
                    div_start  = 1'b1;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (div_stat.done) begin
                    limit_next   = div_quot[LIMIT_W-1:0];
                    latched_next = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    if (monitor_reg && (act_reg == ACT_BASELINE) && (count_reg != COUNT_MAX)) begin
                        sum_next   = sum_reg + SUM_W'(ratio_reg);
                        count_next = count_reg + 1'b1;
                    end
                    if (monitor_reg && (act_reg == ACT_CHECK) && cal_reg) begin
                        if (LIMIT_W'(ratio_reg) >= limit_reg) begin
                            if (hits_reg != HIT_MAX) begin
                                hits_next = hits_reg + 1'b1;
                            end
                            if ((hits_next >= thresh_reg) && !detected_reg) begin
                                detected_next = 1'b1;
                                pulse         = 1'b1;
                            end
                        end else if (!detected_reg) begin
                            hits_next = '0;
                        end
                    end
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_W'({pulse, detected_next, hits_next,
                                            average_reg, ratio_reg});
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            monitor_reg  <= MONITOR_RST;
            rise_pct_reg <= RISE_RST;
            thresh_reg   <= THRESH_RST;
            sum_reg      <= '0;
            count_reg    <= '0;
            latched_reg  <= 1'b0;
            average_reg  <= '0;
            limit_reg    <= '0;
            hits_reg     <= '0;
            detected_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            latched_reg  <= latched_next;
            average_reg  <= average_next;
            limit_reg    <= limit_next;
            hits_reg     <= hits_next;
            detected_reg <= detected_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_MONITOR: monitor_reg  <= cfg_wdata[0];
                    CFG_RISE:    rise_pct_reg <= cfg_wdata[PCT_W-1:0];
                    CFG_THRESH:  thresh_reg   <= cfg_wdata[HIT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg   <= s_tuser[1:0];
            cal_reg   <= s_tuser[2];
            red_reg   <= s_tdata[SENS_W-1:0];
            green_reg <= s_tdata[LEVEL_W +: SENS_W];
        end
        ratio_reg   <= ratio_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `ASSERT_IMPL(a_pulse_has_detect, m_tvalid && m_tdata[73], m_tdata[72])
    `ASSERT_NEXT(a_detect_sticky, detected_reg, detected_reg)
    `ASSERT_NEXT(a_latch_sticky, latched_reg, latched_reg)
    `ASSERT_IMPL(a_units_exclusive, div_stat.busy, !mul_stat.busy)
    `ASSERT_IMPL(a_idle_units_quiet, state_reg == ST_IDLE, !div_stat.busy && !mul_stat.busy)

endmodule
